// ===== rtl/sbht_pkg.sv =====
// ----------------------------------------------------------------------------
// sbht_pkg
// shared widths, constants and payload types of the swept box hit time core
// ----------------------------------------------------------------------------
package sbht_pkg;

	localparam int unsigned DW    = 32;        // field width
	localparam int unsigned SW    = 50;        // signed position / travel width
	localparam int unsigned MW    = SW;        // magnitude width
	localparam int unsigned HW    = MW / 2;    // half magnitude for square split
	localparam int unsigned QW    = 2 * MW;    // sum of squares width
	localparam int unsigned EW    = 17;        // epsilon divisor width
	localparam int unsigned KW    = MW + EW;   // scaled margin width
	localparam int unsigned FW    = 16;        // ratio fraction bits
	localparam int unsigned RW    = FW + 1;    // ratio width, holds one
	localparam int unsigned NROOT = MW;        // square root steps
	localparam int unsigned NDIV  = 4;         // edge dividers
	localparam int unsigned NMK   = 6;         // scaled margins

	localparam logic [EW-1:0] EPS_DIV   = EW'(100000);
	localparam logic [RW-1:0] RATIO_ONE = RW'(65536);

	// edge divider slots
	localparam int unsigned DV_LX = 0;
	localparam int unsigned DV_HX = 1;
	localparam int unsigned DV_LY = 2;
	localparam int unsigned DV_HY = 3;

	// scaled margin slots
	localparam int unsigned MK_DX = 0;
	localparam int unsigned MK_DY = 1;
	localparam int unsigned MK_LX = 2;
	localparam int unsigned MK_HX = 3;
	localparam int unsigned MK_LY = 4;
	localparam int unsigned MK_HY = 5;

	typedef struct packed {
		logic signed [DW-1:0] start_x;
		logic signed [DW-1:0] start_y;
		logic signed [DW-1:0] rel_vel_x;
		logic signed [DW-1:0] rel_vel_y;
		logic signed [DW-1:0] zone_min_x;
		logic signed [DW-1:0] zone_min_y;
		logic signed [DW-1:0] zone_max_x;
		logic signed [DW-1:0] zone_max_y;
		logic [DW-1:0]        time_min;
		logic [DW-1:0]        time_max;
	} req_t;

	typedef struct packed {
		logic [DW-1:0] hit_time;
		logic          already_overlapping;
	} rsp_t;

	typedef struct packed {
		logic [MW:0]   r;
		logic [MW-1:0] den;
		logic [FW-1:0] q;
		logic          ok;
		logic          neg;
	} div_t;

	typedef struct packed {
		div_t [NDIV-1:0]         dv;
		logic [NMK-1:0][KW-1:0]  mk;
		logic [NMK-1:0]          pos;
		logic [1:0]              betw;
		logic [DW-1:0]           t0;
		logic [DW-1:0]           t1;
	} cry_t;

	typedef struct packed {
		logic [QW-1:0] rem;
		logic [QW-1:0] root;
		cry_t          cry;
	} lng_t;

endpackage

// ===== rtl/sbht_stream_if.sv =====
// ----------------------------------------------------------------------------
// sbht_stream_if
// valid/ready channel carrying one item of payload type T
// ----------------------------------------------------------------------------
interface sbht_stream_if #(parameter type T = logic);

	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
	modport mon    (input valid, input data, input ready);

endinterface

// ===== rtl/swept_box_hit_time_core.sv =====
// ----------------------------------------------------------------------------
// swept_box_hit_time_core
// first contact time of a point sweeping through a 2d zone, Q16.16 fixed point
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless a stalled result holds the pipe; depth set by the 50-step square root ladder
// a stalled result freezes every stage, nothing is dropped or repeated
// reset: arst_n clears all stage valid bits at once, payload is not reset
// ----------------------------------------------------------------------------
module swept_box_hit_time_core (
	input  logic          clk,
	input  logic          arst_n,
	sbht_stream_if.sink   req,
	sbht_stream_if.source rsp
);
	import sbht_pkg::*;

	// one restoring step of an edge ratio division
	function automatic div_t div_step(div_t d);
		div_t          y;
		logic [MW:0]   r2;
		logic          hit;
		y   = d;
		r2  = {d.r[MW-1:0], 1'b0};
		hit = (r2 >= {1'b0, d.den});
		y.r = hit ? (r2 - {1'b0, d.den}) : r2;
		y.q = {d.q[FW-2:0], hit};
		return y;
	endfunction

	// one digit of the square root, plus a divider step in the early stages
	function automatic lng_t root_step(lng_t x, int unsigned k);
		lng_t          y;
		logic [QW-1:0] bit_v;
		logic [QW-1:0] trial;
		y     = x;
		bit_v = QW'(1) << (2 * (NROOT - 1 - k));
		trial = x.root + bit_v;
		if (x.rem >= trial) begin
			y.rem  = x.rem - trial;
			y.root = (x.root >> 1) + bit_v;
		end else begin
			y.root = x.root >> 1;
		end
		if (k < FW) begin
			for (int i = 0; i < NDIV; i++) begin
				y.cry.dv[i] = div_step(x.cry.dv[i]);
			end
		end
		return y;
	endfunction

	// valid bits
	logic             vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [NROOT-1:0] vld_s7;
	logic             vld_s57, vld_s58, vld_s59, vld_s60;

	// whole pipe moves when the output slot is free or being taken
	logic adv;
	assign adv       = !vld_s60 || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= '0;
			vld_s57 <= 1'b0;
			vld_s58 <= 1'b0;
			vld_s59 <= 1'b0;
			vld_s60 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= req.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= {vld_s7[NROOT-2:0], vld_s6};
			vld_s57 <= vld_s7[NROOT-1];
			vld_s58 <= vld_s57;
			vld_s59 <= vld_s58;
			vld_s60 <= vld_s59;
		end
	end

	// ------------------------------------------------------------------
	// stage 1: velocity times window ends, exact 65-bit products
	// ------------------------------------------------------------------
	logic signed [2*DW:0] pvx0_s1, pvx1_s1, pvy0_s1, pvy1_s1;
	logic signed [DW-1:0] px_s1, py_s1, lox_s1, loy_s1, hix_s1, hiy_s1;
	logic [DW-1:0]        t0_s1, t1_s1;

	// ------------------------------------------------------------------
	// stage 2: start point and travel; travel needs no position since it cancels
	// ------------------------------------------------------------------
	logic signed [SW-1:0] sx_c, sy_c, dx_c, dy_c;
	logic signed [SW-1:0] sx_s2, sy_s2, dx_s2, dy_s2;
	logic signed [DW-1:0] lox_s2, loy_s2, hix_s2, hiy_s2;
	logic [DW-1:0]        t0_s2, t1_s2;

	always_comb begin
		// floor to Q16.16 is an arithmetic drop of the low 16 bits
		sx_c = SW'(px_s1) + SW'($signed(pvx0_s1[2*DW:FW]));
		sy_c = SW'(py_s1) + SW'($signed(pvy0_s1[2*DW:FW]));
		dx_c = SW'($signed(pvx1_s1[2*DW:FW])) - SW'($signed(pvx0_s1[2*DW:FW]));
		dy_c = SW'($signed(pvy1_s1[2*DW:FW])) - SW'($signed(pvy0_s1[2*DW:FW]));
	end

	// ------------------------------------------------------------------
	// stage 3: magnitudes and signs of travel and of edge distances
	// ------------------------------------------------------------------
	logic [MW-1:0]            mx_c, my_c;
	logic [NDIV-1:0][MW-1:0]  nm_c;
	logic [NDIV-1:0]          ns_c;
	logic signed [SW-1:0]     ep_c [NDIV];
	logic signed [SW-1:0]     en_c [NDIV];

	logic [MW-1:0]            mx_s3, my_s3;
	logic                     dxs_s3, dys_s3;
	logic [NDIV-1:0][MW-1:0]  nm_s3;
	logic [NDIV-1:0]          ns_s3;
	logic [DW-1:0]            t0_s3, t1_s3;

	always_comb begin
		mx_c = dx_s2[SW-1] ? MW'(-dx_s2) : MW'(dx_s2);
		my_c = dy_s2[SW-1] ? MW'(-dy_s2) : MW'(dy_s2);
		// edge minus start, and its negation, side by side
		ep_c[DV_LX] = SW'(lox_s2) - sx_s2;
		ep_c[DV_HX] = SW'(hix_s2) - sx_s2;
		ep_c[DV_LY] = SW'(loy_s2) - sy_s2;
		ep_c[DV_HY] = SW'(hiy_s2) - sy_s2;
		en_c[DV_LX] = sx_s2 - SW'(lox_s2);
		en_c[DV_HX] = sx_s2 - SW'(hix_s2);
		en_c[DV_LY] = sy_s2 - SW'(loy_s2);
		en_c[DV_HY] = sy_s2 - SW'(hiy_s2);
		for (int i = 0; i < NDIV; i++) begin
			ns_c[i] = ep_c[i][SW-1];
			nm_c[i] = ns_c[i] ? MW'(en_c[i]) : MW'(ep_c[i]);
		end
	end

	// ------------------------------------------------------------------
	// stage 4: square partials, scaled margins, divider setup
	// ------------------------------------------------------------------
	logic [2*HW-1:0] xhh_s4, xhl_s4, xll_s4, yhh_s4, yhl_s4, yll_s4;
	cry_t            cry_c4, cry_s4;

	always_comb begin
		// a margin m beats eps = floor(len / 100000) exactly when m > 0 and len < m * 100000
		cry_c4.mk[MK_DX] = KW'(mx_s3) * KW'(EPS_DIV);
		cry_c4.mk[MK_DY] = KW'(my_s3) * KW'(EPS_DIV);
		cry_c4.mk[MK_LX] = KW'(nm_s3[DV_LX]) * KW'(EPS_DIV);
		cry_c4.mk[MK_HX] = KW'(nm_s3[DV_HX]) * KW'(EPS_DIV);
		cry_c4.mk[MK_LY] = KW'(nm_s3[DV_LY]) * KW'(EPS_DIV);
		cry_c4.mk[MK_HY] = KW'(nm_s3[DV_HY]) * KW'(EPS_DIV);
		cry_c4.pos[MK_DX] = (mx_s3 != '0);
		cry_c4.pos[MK_DY] = (my_s3 != '0);
		// start above the low edge and below the high edge
		cry_c4.pos[MK_LX] = ns_s3[DV_LX];
		cry_c4.pos[MK_HX] = !ns_s3[DV_HX] && (nm_s3[DV_HX] != '0);
		cry_c4.pos[MK_LY] = ns_s3[DV_LY];
		cry_c4.pos[MK_HY] = !ns_s3[DV_HY] && (nm_s3[DV_HY] != '0);
		cry_c4.betw[0] = cry_c4.pos[MK_LX] && cry_c4.pos[MK_HX];
		cry_c4.betw[1] = cry_c4.pos[MK_LY] && cry_c4.pos[MK_HY];
		for (int i = 0; i < NDIV; i++) begin
			cry_c4.dv[i].den = (i < 2) ? mx_s3 : my_s3;
			cry_c4.dv[i].r   = {1'b0, nm_s3[i]};
			cry_c4.dv[i].q   = '0;
			cry_c4.dv[i].ok  = (nm_s3[i] < cry_c4.dv[i].den);
			cry_c4.dv[i].neg = ns_s3[i] ^ ((i < 2) ? dxs_s3 : dys_s3);
		end
		cry_c4.t0 = t0_s3;
		cry_c4.t1 = t1_s3;
	end

	// ------------------------------------------------------------------
	// stage 5: per-axis squares, stage 6: sum of squares
	// ------------------------------------------------------------------
	logic [QW-1:0] sqx_s5, sqy_s5;
	cry_t          cry_s5;
	lng_t          root_s6;

	// ------------------------------------------------------------------
	// stages 7 to 56: square root ladder, dividers run in the first 16
	// ------------------------------------------------------------------
	lng_t root_s7 [NROOT];

	// ------------------------------------------------------------------
	// stage 57: epsilon tests and per-edge candidates
	// ------------------------------------------------------------------
	logic [MW-1:0]           len_c;
	logic [NMK-1:0]          flg_c;
	logic [NDIV-1:0][RW-1:0] cnd_c;
	div_t                    dv_c;

	logic [NMK-1:0]          flg_s57;
	logic [NDIV-1:0][RW-1:0] cnd_s57;
	logic [1:0]              betw_s57;
	logic [DW-1:0]           t0_s57, t1_s57;

	always_comb begin
		len_c = root_s7[NROOT-1].root[MW-1:0];
		dv_c  = root_s7[NROOT-1].cry.dv[0];
		for (int i = 0; i < NMK; i++) begin
			flg_c[i] = root_s7[NROOT-1].cry.pos[i] &&
				(KW'(len_c) < root_s7[NROOT-1].cry.mk[i]);
		end
		for (int i = 0; i < NDIV; i++) begin
			dv_c = root_s7[NROOT-1].cry.dv[i];
			// a negative ratio that truncates to zero still counts as a hit
			cnd_c[i] = (dv_c.ok && !(dv_c.neg && (dv_c.q != '0))) ?
				{1'b0, dv_c.q} : RATIO_ONE;
		end
	end

	// ------------------------------------------------------------------
	// stage 58: axis ratios, their max, and the overlap test
	// ------------------------------------------------------------------
	logic [RW-1:0]        rx_c, ry_c, mnx_c, mny_c;
	logic [RW-1:0]        ratio_s58;
	logic                 ovl_s58;
	logic signed [DW:0]   dt_s58;
	logic [DW-1:0]        t0_s58;

	always_comb begin
		mnx_c = (cnd_s57[DV_LX] < cnd_s57[DV_HX]) ? cnd_s57[DV_LX] : cnd_s57[DV_HX];
		mny_c = (cnd_s57[DV_LY] < cnd_s57[DV_HY]) ? cnd_s57[DV_LY] : cnd_s57[DV_HY];
		// short travel: inside the slab is a hit at once, else no hit
		rx_c = flg_s57[MK_DX] ? mnx_c : (betw_s57[0] ? '0 : RATIO_ONE);
		ry_c = flg_s57[MK_DY] ? mny_c : (betw_s57[1] ? '0 : RATIO_ONE);
	end

	// ------------------------------------------------------------------
	// stage 59: window length times ratio
	// ------------------------------------------------------------------
	logic signed [DW+RW+1:0] prod_s59;
	logic                    ovl_s59;
	logic [DW-1:0]           t0_s59;

	// ------------------------------------------------------------------
	// stage 60: output register, interpolated time clamped to 32 bits
	// ------------------------------------------------------------------
	logic signed [DW+RW+2:0] tsum_c;
	rsp_t                    out_c, out_s60;

	always_comb begin
		tsum_c = (DW+RW+3)'($signed({1'b0, t0_s59})) +
			(DW+RW+3)'($signed(prod_s59[DW+RW+1:FW]));
		out_c.already_overlapping = ovl_s59;
		if (ovl_s59 || tsum_c < 0) begin
			out_c.hit_time = '0;
		end else if (tsum_c > (DW+RW+3)'($signed({1'b0, {DW{1'b1}}}))) begin
			out_c.hit_time = '1;
		end else begin
			out_c.hit_time = tsum_c[DW-1:0];
		end
	end

	assign rsp.valid = vld_s60;
	assign rsp.data  = out_s60;

	// payload registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			pvx0_s1 <= req.data.rel_vel_x * $signed({1'b0, req.data.time_min});
			pvx1_s1 <= req.data.rel_vel_x * $signed({1'b0, req.data.time_max});
			pvy0_s1 <= req.data.rel_vel_y * $signed({1'b0, req.data.time_min});
			pvy1_s1 <= req.data.rel_vel_y * $signed({1'b0, req.data.time_max});
			px_s1   <= req.data.start_x;
			py_s1   <= req.data.start_y;
			lox_s1  <= req.data.zone_min_x;
			loy_s1  <= req.data.zone_min_y;
			hix_s1  <= req.data.zone_max_x;
			hiy_s1  <= req.data.zone_max_y;
			t0_s1   <= req.data.time_min;
			t1_s1   <= req.data.time_max;
			// stage 2
			sx_s2  <= sx_c;
			sy_s2  <= sy_c;
			dx_s2  <= dx_c;
			dy_s2  <= dy_c;
			lox_s2 <= lox_s1;
			loy_s2 <= loy_s1;
			hix_s2 <= hix_s1;
			hiy_s2 <= hiy_s1;
			t0_s2  <= t0_s1;
			t1_s2  <= t1_s1;
			// stage 3
			mx_s3  <= mx_c;
			my_s3  <= my_c;
			dxs_s3 <= dx_s2[SW-1];
			dys_s3 <= dy_s2[SW-1];
			nm_s3  <= nm_c;
			ns_s3  <= ns_c;
			t0_s3  <= t0_s2;
			t1_s3  <= t1_s2;
			// stage 4
			xhh_s4 <= (2*HW)'(mx_s3[MW-1:HW]) * (2*HW)'(mx_s3[MW-1:HW]);
			xhl_s4 <= (2*HW)'(mx_s3[MW-1:HW]) * (2*HW)'(mx_s3[HW-1:0]);
			xll_s4 <= (2*HW)'(mx_s3[HW-1:0]) * (2*HW)'(mx_s3[HW-1:0]);
			yhh_s4 <= (2*HW)'(my_s3[MW-1:HW]) * (2*HW)'(my_s3[MW-1:HW]);
			yhl_s4 <= (2*HW)'(my_s3[MW-1:HW]) * (2*HW)'(my_s3[HW-1:0]);
			yll_s4 <= (2*HW)'(my_s3[HW-1:0]) * (2*HW)'(my_s3[HW-1:0]);
			cry_s4 <= cry_c4;
			// stage 5
			sqx_s5 <= (QW'(xhh_s4) << (2*HW)) + (QW'(xhl_s4) << (HW+1)) + QW'(xll_s4);
			sqy_s5 <= (QW'(yhh_s4) << (2*HW)) + (QW'(yhl_s4) << (HW+1)) + QW'(yll_s4);
			cry_s5 <= cry_s4;
			// stage 6
			root_s6.rem  <= sqx_s5 + sqy_s5;
			root_s6.root <= '0;
			root_s6.cry  <= cry_s5;
			// stages 7 to 56
			root_s7[0] <= root_step(root_s6, 0);
			for (int k = 1; k < NROOT; k++) begin
				root_s7[k] <= root_step(root_s7[k-1], k);
			end
			// stage 57
			flg_s57  <= flg_c;
			cnd_s57  <= cnd_c;
			betw_s57 <= root_s7[NROOT-1].cry.betw;
			t0_s57   <= root_s7[NROOT-1].cry.t0;
			t1_s57   <= root_s7[NROOT-1].cry.t1;
			// stage 58
			ratio_s58 <= (rx_c > ry_c) ? rx_c : ry_c;
			ovl_s58   <= flg_s57[MK_LX] && flg_s57[MK_HX] &&
				flg_s57[MK_LY] && flg_s57[MK_HY];
			dt_s58    <= $signed({1'b0, t1_s57}) - $signed({1'b0, t0_s57});
			t0_s58    <= t0_s57;
			// stage 59
			prod_s59 <= (DW+RW+2)'(dt_s58) * (DW+RW+2)'($signed({1'b0, ratio_s58}));
			ovl_s59  <= ovl_s58;
			t0_s59   <= t0_s58;
			// stage 60
			out_s60 <= out_c;
		end
	end

endmodule

// ===== rtl/sbht_chk.sv =====
// ----------------------------------------------------------------------------
// sbht_chk
// port-level checks of the swept box hit time core, bound into the core
// ----------------------------------------------------------------------------
module sbht_chk (
	input logic           clk,
	input logic           arst_n,
	sbht_stream_if.sink   req,
	sbht_stream_if.source rsp
);

	// input side opens exactly when the output slot frees up
	a_ready_follows_out: assert property (@(posedge clk)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("req.ready does not follow output slot");

	// no item shown while in reset
	a_rst_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp.valid)
		else $error("rsp.valid high during reset");

	// a stalled item holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("stalled result item changed");

	// overlap at window start reports time zero
	a_ovl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.already_overlapping |-> rsp.data.hit_time == '0)
		else $error("overlap item with nonzero hit_time");

endmodule

bind swept_box_hit_time_core sbht_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.req    (req),
	.rsp    (rsp)
);
